// File: src/dense_residual_matvec_macros.svh
// Assertion macros used by the residual engine RTL.
`ifndef DENSE_RESIDUAL_MATVEC_MACROS_SVH
`define DENSE_RESIDUAL_MATVEC_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DRMV_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("residual engine check failed");

`define DRMV_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("residual engine check failed");

`else

`define DRMV_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define DRMV_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: src/drmv_pkg.sv
// Shared types, constants and helpers for the dense residual engine.
package drmv_pkg;

    localparam int SEL_W = 6;
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;
    localparam int SIZE_W = 7;
    localparam int DIM_LIMIT = 64;
    localparam int MAX_DIM_DEFAULT = 64;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W = 72;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [ACC_W-1:0] ROUND_HALF = 72'h8000;
    localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_X  = 2'd1,
        REQ_LOAD_B  = 2'd2,
        REQ_COMPUTE = 2'd3
    } req_t;

    typedef struct packed {
        logic             mat_we;
        logic             x_we;
        logic             b_we;
        logic [SEL_W-1:0] row;
        logic [SEL_W-1:0] col;
        logic [VAL_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [SEL_W-1:0] row;
        logic [SEL_W-1:0] col;
    } rd_req_t;

    // Largest usable dimension: the MAX_DIM parameter and the 6-bit indexes both limit it.
    function automatic int dim_cap(int max_dim);
        return (max_dim < DIM_LIMIT) ? max_dim : DIM_LIMIT;
    endfunction

endpackage

// File: src/drmv_store.sv
// Matrix, x and right-hand-side memories with one write and one registered read port.
module drmv_store #(
    parameter int MAX_DIM = drmv_pkg::MAX_DIM_DEFAULT
) (
    input  logic                         clk,
    input  drmv_pkg::wr_req_t            wr,
    input  drmv_pkg::rd_req_t            rd,
    output logic [drmv_pkg::VAL_W-1:0]   a_rdata,
    output logic [drmv_pkg::VAL_W-1:0]   x_rdata,
    output logic [drmv_pkg::VAL_W-1:0]   b_rdata
);

    localparam int Cap = drmv_pkg::dim_cap(MAX_DIM);
    localparam int RowW = $clog2(Cap);
    localparam int Depth = Cap * Cap;
    localparam int MatAw = $clog2(Depth);

    logic [drmv_pkg::VAL_W-1:0] mat_mem [Depth];
    logic [drmv_pkg::VAL_W-1:0] x_mem [Cap];
    logic [drmv_pkg::VAL_W-1:0] b_mem [Cap];

    logic [MatAw-1:0] wr_addr;
    logic [MatAw-1:0] rd_addr;
    logic [drmv_pkg::VAL_W-1:0] a_rdata_reg;
    logic [drmv_pkg::VAL_W-1:0] x_rdata_reg;
    logic [drmv_pkg::VAL_W-1:0] b_rdata_reg;

    assign wr_addr = MatAw'(int'(wr.row[RowW-1:0]) * Cap + int'(wr.col[RowW-1:0]));
    assign rd_addr = MatAw'(int'(rd.row[RowW-1:0]) * Cap + int'(rd.col[RowW-1:0]));

    always_ff @(posedge clk)
    begin
        if (wr.mat_we)
        begin
            mat_mem[wr_addr] <= wr.data;
        end
        if (wr.x_we)
        begin
            x_mem[wr.row[RowW-1:0]] <= wr.data;
        end
        if (wr.b_we)
        begin
            b_mem[wr.row[RowW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            a_rdata_reg <= mat_mem[rd_addr];
            x_rdata_reg <= x_mem[rd.col[RowW-1:0]];
            b_rdata_reg <= b_mem[rd.row[RowW-1:0]];
        end
    end

    assign a_rdata = a_rdata_reg;
    assign x_rdata = x_rdata_reg;
    assign b_rdata = b_rdata_reg;

endmodule

// File: src/dense_residual_matvec.sv
// Load requests are accepted back to back while the engine is idle.
// A compute request walks the matrix one entry per cycle while it issues reads: for each row
// it issues n memory reads, lets the pipeline multiply, accumulate and round the sum, then
// emits the residual; the next row starts only after that emit, and a stalled output holds it.
// The memory read port and the single multiply-accumulate unit bound the pace of each run.
// Reset clears control state and sets the dimension to 64; the memories are not cleared.
`include "dense_residual_matvec_macros.svh"

module dense_residual_matvec #(
    parameter int MAX_DIM = drmv_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [drmv_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // row_sel, col_sel, load_value, pad
    input  logic [drmv_pkg::REQ_W-1:0]    s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // out_row, residual, pad
    output logic                          m_tuser,   // saturated
    output logic                          m_tlast
);

    localparam int Cap = drmv_pkg::dim_cap(MAX_DIM);
    localparam int RowW = $clog2(Cap);
    localparam int SelW = drmv_pkg::SEL_W;
    localparam int ValW = drmv_pkg::VAL_W;
    localparam int AccW = drmv_pkg::ACC_W;
    localparam int FracW = drmv_pkg::FRAC_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [RowW-1:0] row_reg, row_next;
    logic [RowW-1:0] col_reg, col_next;
    logic [RowW-1:0] nlast_reg, nlast_next;
    logic [drmv_pkg::SIZE_W-1:0] size_reg;
    logic m_valid_reg, m_valid_next;
    logic [SelW-1:0] out_row_reg, out_row_next;
    logic [ValW-1:0] res_reg, res_next;
    logic sat_reg, sat_next;
    logic last_reg, last_next;

    drmv_pkg::req_t in_req;
    logic [SelW-1:0] in_row;
    logic [SelW-1:0] in_col;
    logic [ValW-1:0] in_val;
    logic accept;
    logic row_ok;
    logic col_ok;
    logic [RowW-1:0] dim_last;

    drmv_pkg::wr_req_t wr;
    drmv_pkg::rd_req_t rd;
    logic [ValW-1:0] a_rdata;
    logic [ValW-1:0] x_rdata;
    logic [ValW-1:0] b_rdata;

    logic issue;
    logic p0_valid_reg, p0_first_reg, p0_last_reg;
    logic p1_valid_reg, p1_first_reg, p1_last_reg;
    logic fin_reg;
    logic signed [drmv_pkg::PROD_W-1:0] prod_reg;
    logic [ValW-1:0] b_reg;
    logic [AccW-1:0] acc_reg;
    logic [AccW-1:0] rnd_reg;
    logic [AccW-1:0] b_ext;
    logic [AccW-1:0] prod_ext;
    logic fits;
    logic out_free;

    assign in_req = drmv_pkg::req_t'(s_tuser);
    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_val = s_tdata[43:12];
    assign accept = s_tvalid && s_tready;
    assign row_ok = int'(in_row) < Cap;
    assign col_ok = int'(in_col) < Cap;

    // Loads and compute reads never share a cycle: loads are taken only while idle.
    always_comb
    begin
        wr.mat_we = accept && (in_req == drmv_pkg::REQ_LOAD_A) && row_ok && col_ok;
        wr.x_we = accept && (in_req == drmv_pkg::REQ_LOAD_X) && row_ok;
        wr.b_we = accept && (in_req == drmv_pkg::REQ_LOAD_B) && row_ok;
        wr.row = in_row;
        wr.col = in_col;
        wr.data = in_val;
    end

    assign issue = (state_reg == ST_ISSUE);

    always_comb
    begin
        rd.en = issue;
        rd.row = SelW'(row_reg);
        rd.col = SelW'(col_reg);
    end

    drmv_store #(
        .MAX_DIM(MAX_DIM)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .a_rdata (a_rdata),
        .x_rdata (x_rdata),
        .b_rdata (b_rdata)
    );

    always_comb
    begin
        priority if (size_reg == '0)
        begin
            dim_last = '0;
        end
        else if (int'(size_reg) > Cap)
        begin
            dim_last = RowW'(Cap - 1);
        end
        else
        begin
            dim_last = RowW'(size_reg - 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= drmv_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate, round.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p0_first_reg <= 1'b0;
            p0_last_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p1_first_reg <= 1'b0;
            p1_last_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            p0_valid_reg <= issue;
            p0_first_reg <= issue && (col_reg == '0);
            p0_last_reg <= issue && (col_reg == nlast_reg);
            p1_valid_reg <= p0_valid_reg;
            p1_first_reg <= p0_first_reg;
            p1_last_reg <= p0_last_reg;
            fin_reg <= p1_valid_reg && p1_last_reg;
        end
    end

    assign b_ext = {{(AccW - ValW - FracW){b_reg[ValW-1]}}, b_reg, {FracW{1'b0}}};
    assign prod_ext = {{(AccW - drmv_pkg::PROD_W){prod_reg[drmv_pkg::PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (p0_valid_reg)
        begin
            prod_reg <= $signed(a_rdata) * $signed(x_rdata);
        end
        if (p0_first_reg)
        begin
            b_reg <= b_rdata;
        end
        if (p1_valid_reg)
        begin
            acc_reg <= (p1_first_reg ? b_ext : acc_reg) - prod_ext;
        end
        if (fin_reg)
        begin
            rnd_reg <= acc_reg + drmv_pkg::ROUND_HALF;
        end
    end

    // The rounded value fits Q16.16 when every bit above the result's sign bit matches it.
    assign fits = (&rnd_reg[AccW-1:ValW+FracW-1]) || !(|rnd_reg[AccW-1:ValW+FracW-1]);
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        nlast_next = nlast_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_row_next = out_row_reg;
        res_next = res_reg;
        sat_next = sat_reg;
        last_next = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_req == drmv_pkg::REQ_COMPUTE))
                begin
                    row_next = '0;
                    col_next = '0;
                    nlast_next = dim_last;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                col_next = col_reg + 1'b1;
                if (col_reg == nlast_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (fin_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    out_row_next = SelW'(row_reg);
                    res_next = fits ? rnd_reg[ValW+FracW-1:FracW]
                        : (rnd_reg[AccW-1] ? drmv_pkg::SAT_NEG : drmv_pkg::SAT_POS);
                    sat_next = !fits;
                    last_next = (row_reg == nlast_reg);
                    if (row_reg == nlast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        col_next = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg <= '0;
            col_reg <= '0;
            nlast_reg <= '0;
            m_valid_reg <= 1'b0;
            out_row_reg <= '0;
            res_reg <= '0;
            sat_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            nlast_reg <= nlast_next;
            m_valid_reg <= m_valid_next;
            out_row_reg <= out_row_next;
            res_reg <= res_next;
            sat_reg <= sat_next;
            last_reg <= last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {2'b00, res_reg, out_row_reg};
    assign m_tuser = sat_reg;
    assign m_tlast = last_reg;

    `DRMV_ASSERT_IMPLIES(a_idle_pipe_empty, clk, rst_n, s_tready,
        !p0_valid_reg && !p1_valid_reg && !fin_reg)
    `DRMV_ASSERT_IMPLIES(a_fin_in_flush, clk, rst_n, fin_reg, state_reg == ST_FLUSH)
    `DRMV_ASSERT_IMPLIES(a_sat_extreme, clk, rst_n, m_tvalid && m_tuser,
        (res_reg == drmv_pkg::SAT_POS) || (res_reg == drmv_pkg::SAT_NEG))
    `DRMV_ASSERT_NEXT(a_issue_reads, clk, rst_n, issue, p0_valid_reg)

endmodule

// File: verif/testbench.sv
// Self-checking bench for the dense residual engine: loads A, x and b and checks every residual.
module testbench;
    import drmv_pkg::*;

    localparam int DIM = DIM_LIMIT;
    localparam int FILL_DIM = 8;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int QUIET_CYCLES = 8;

    typedef struct {
        logic [SEL_W-1:0] row;
        logic [VAL_W-1:0] value;
        logic             sat;
        logic             last;
    } row_result_t;

    // Tracks the stored system and the rows still owed by the engine.
    class residual_predictor;
        logic [VAL_W-1:0]  a_store [DIM*DIM];
        logic [VAL_W-1:0]  x_store [DIM];
        logic [VAL_W-1:0]  b_store [DIM];
        logic [SIZE_W-1:0] size_reg;
        row_result_t       pending_rows [$];
        int                errors;

        function new();
            size_reg = SIZE_RESET;
            errors = 0;
        endfunction

        function int active_rows();
            if (size_reg == 0)
                return 1;
            if (size_reg > DIM)
                return DIM;
            return int'(size_reg);
        endfunction

        function row_result_t row_residual(int r, int n);
            logic signed [79:0] acc;
            logic signed [63:0] prod;
            logic signed [31:0] a_v;
            logic signed [31:0] x_v;
            logic signed [31:0] b_v;
            row_result_t        res;
            int                 j;
            b_v = b_store[r];
            acc = 80'(b_v);
            acc = acc <<< FRAC_W;
            for (j = 0; j < n; j++)
            begin
                a_v = a_store[r*DIM + j];
                x_v = x_store[j];
                prod = 64'(a_v) * 64'(x_v);
                acc = acc - 80'(prod);
            end
            // Round half an LSB up, then drop the extra fraction bits.
            acc = acc + 80'sd32768;
            acc = acc >>> FRAC_W;
            res.row = 6'(r);
            res.last = (r == n - 1);
            if (acc > 80'sd2147483647)
            begin
                res.value = SAT_POS;
                res.sat = 1'b1;
            end
            else if (acc < -80'sd2147483648)
            begin
                res.value = SAT_NEG;
                res.sat = 1'b1;
            end
            else
            begin
                res.value = acc[31:0];
                res.sat = 1'b0;
            end
            return res;
        endfunction

        function void note_request(req_t kind, logic [SEL_W-1:0] row, logic [SEL_W-1:0] col,
                                   logic [VAL_W-1:0] val);
            int n;
            int r;
            case (kind)
                REQ_LOAD_A: a_store[row*DIM + col] = val;
                REQ_LOAD_X: x_store[row] = val;
                REQ_LOAD_B: b_store[row] = val;
                REQ_COMPUTE:
                begin
                    n = active_rows();
                    for (r = 0; r < n; r++)
                        pending_rows.push_back(row_residual(r, n));
                end
            endcase
        endfunction

        function void check_row(logic [SEL_W-1:0] row, logic [VAL_W-1:0] value, logic sat,
                                logic last);
            row_result_t want;
            if (pending_rows.size() == 0)
            begin
                $error("residual for row %0d arrived with none outstanding", row);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            if (row !== want.row)
            begin
                $error("out_row: expected %0d, got %0d", want.row, row);
                errors++;
            end
            if (value !== want.value)
            begin
                $error("residual: expected %h, got %h", want.value, value);
                errors++;
            end
            if (sat !== want.sat)
            begin
                $error("saturated: expected %b, got %b", want.sat, sat);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;
    logic [REQ_W-1:0]  s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    residual_predictor pred;
    int                src_idle_pct = 33;
    int                dst_idle_pct = 53;
    int                cycle_count = 0;

    dense_residual_matvec uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pred.check_row(m_tdata[5:0], m_tdata[37:6], m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dense_residual_matvec: mismatch");
            $finish;
        end
    end

    task automatic send_request(req_t kind, logic [SEL_W-1:0] row, logic [SEL_W-1:0] col,
                                logic [VAL_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0, val, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred.note_request(kind, row, col, val);
    endtask

    // Stop sending and wait until every owed residual is back and the engine is quiet.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pred.pending_rows.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        pred.size_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value(bit narrow);
        int sel;
        sel = $urandom_range(99);
        if (sel < (narrow ? 2 : 10))
        begin
            case ($urandom_range(4))
                0: return SAT_POS;
                1: return SAT_NEG;
                2: return '0;
                3: return '1;
                default: return 32'h0000_8000;
            endcase
        end
        // Mostly within plus or minus 4.0 so that long rows do not always clip.
        if (narrow || sel < 60)
            return $urandom_range(32'h0008_0000) - 32'h0004_0000;
        return $urandom();
    endfunction

    task automatic unit_case(logic [VAL_W-1:0] a, logic [VAL_W-1:0] x, logic [VAL_W-1:0] b);
        send_request(REQ_LOAD_A, '0, '0, a);
        send_request(REQ_LOAD_X, '0, '0, x);
        send_request(REQ_LOAD_B, '0, '0, b);
        send_request(REQ_COMPUTE, 6'($urandom_range(63)), 6'($urandom_range(63)), $urandom());
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] size_val, int items);
        int               n;
        int               i;
        int               sel;
        int               computes;
        int               max_computes;
        logic [SEL_W-1:0] row;
        logic [SEL_W-1:0] col;
        settle();
        write_size(size_val);
        n = pred.active_rows();
        // Compute requests on large systems walk n * n matrix entries, so keep those rare.
        max_computes = (n > 16) ? 2 : items;
        computes = 0;
        for (i = 0; i < items; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 4)
                settle();
            row = ($urandom_range(9) < 7) ? 6'($urandom_range(n - 1)) : 6'($urandom_range(63));
            col = ($urandom_range(9) < 7) ? 6'($urandom_range(n - 1)) : 6'($urandom_range(63));
            if (sel >= 82 && computes < max_computes)
            begin
                send_request(REQ_COMPUTE, row, col, $urandom());
                computes++;
            end
            else
                send_request(req_t'($urandom_range(2)), row, col, pick_value(1'b0));
        end
        if (computes == 0)
            send_request(REQ_COMPUTE, 6'($urandom_range(63)), 6'($urandom_range(63)), $urandom());
    endtask

    initial
    begin
        int r;
        int c;
        pred = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One-by-one system: clipping both ways, ties and the largest value that still fits.
        write_size(7'd1);
        unit_case(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        unit_case(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        unit_case(32'h0000_0001, 32'h0000_8000, 32'h0000_0000);
        unit_case(32'hFFFF_FFFF, 32'h0000_8000, 32'h8000_0000);
        unit_case(32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(REQ_LOAD_A, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_request(REQ_LOAD_X, 6'd63, 6'd0, 32'h8000_0000);
        send_request(REQ_LOAD_B, 6'd63, 6'd63, 32'h7FFF_FFFF);
        settle();
        write_size(7'd0);
        send_request(REQ_COMPUTE, 6'd63, 6'd63, 32'hFFFF_FFFF);

        // Fill the leading block so that every size used below reads written entries only.
        for (r = 0; r < FILL_DIM; r++)
            for (c = 0; c < FILL_DIM; c++)
                send_request(REQ_LOAD_A, 6'(r), 6'(c), pick_value(1'b1));
        for (r = 0; r < FILL_DIM; r++)
        begin
            send_request(REQ_LOAD_X, 6'(r), 6'($urandom_range(63)), pick_value(1'b1));
            send_request(REQ_LOAD_B, 6'(r), 6'($urandom_range(63)), pick_value(1'b1));
        end

        run_phase(7'd2, 6);
        run_phase(7'd8, 6);
        run_phase(7'($urandom_range(3, 7)), 6);

        src_idle_pct = 53;
        dst_idle_pct = 33;
        run_phase(7'd5, 6);
        run_phase(7'd3, 6);
        run_phase(7'($urandom_range(8)), 6);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_phase(7'd1, 6);
        run_phase(7'($urandom_range(4, 8)), 6);
        run_phase(7'd7, 6);

        settle();
        if (pred.errors == 0)
            $display("dense_residual_matvec: match");
        else
            $display("dense_residual_matvec: mismatch");
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/drmv_pkg.sv
src/drmv_store.sv
src/dense_residual_matvec.sv
verif/testbench.sv
